// ===== design/tplc_pkg.sv =====
// Package for the threshold power-law compander.
// Holds the fixed-point widths, constants, side-band type and helpers.
// No dependencies; every design file but the checker imports it.
package tplc_pkg;

    localparam int LOG_FRAC = 28;
    localparam int LG_W     = 36;
    localparam int P_W      = 53;
    localparam int IP_W     = P_W - 42;
    localparam int TERMS    = 12;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [32:0] MAG_BIG = 33'h1_0000_0000;

    localparam logic [1:0] CFG_PRE_GAIN  = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_EXPONENT  = 2'd2;
    localparam logic [1:0] CFG_POST_GAIN = 2'd3;

    typedef struct packed {
        logic        neg;
        logic        pow;
        logic [32:0] bmag;
    } side_t;

    // Reciprocal floor(2^36 / k) for the series divisors.
    function automatic logic [36:0] recip(input int k);
        logic [36:0] r;
        case (k)
            1:       r = 37'd68719476736;
            2:       r = 37'd34359738368;
            3:       r = 37'd22906492245;
            4:       r = 37'd17179869184;
            5:       r = 37'd13743895347;
            6:       r = 37'd11453246122;
            7:       r = 37'd9817068105;
            8:       r = 37'd8589934592;
            9:       r = 37'd7635497415;
            10:      r = 37'd6871947673;
            11:      r = 37'd6247225157;
            12:      r = 37'd5726623061;
            default: r = 37'd0;
        endcase
        return r;
    endfunction

    // Anything at or above 2^32 is reported as 2^32; it saturates either way.
    function automatic logic [32:0] clamp33(input logic [63:0] x);
        return (x > 64'h1_0000_0000) ? MAG_BIG : x[32:0];
    endfunction

endpackage

// ===== design/tplc_front.sv =====
// Front end: sign split, pre-gain product, threshold compare and the
// linear-path rounding. Depends on tplc_pkg.
module tplc_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [SAMPLE_BITS-1:0]    sample,
    input  logic [15:0]               pre_gain,
    input  logic [30:0]               threshold,
    input  logic [15:0]               post_gain,
    output logic                      out_valid,
    output logic [SAMPLE_BITS+15:0]   xmag,
    output tplc_pkg::side_t           side
);
    import tplc_pkg::*;

    localparam int XW  = SAMPLE_BITS + 16;
    localparam int BPW = XW + 16;

    logic [3:0]             vld_reg;
    logic [SAMPLE_BITS-1:0] smag_reg, smag_next;
    logic                   neg1_reg, neg2_reg, neg3_reg;
    logic [XW-1:0]          xmag2_reg, xmag3_reg, xmag4_reg;
    logic [BPW-1:0]         bprod3_reg;
    logic                   pow3_reg;
    side_t                  side4_reg, side4_next;
    logic [63:0]            bsum;

    always_comb
    begin
        smag_next = sample[SAMPLE_BITS-1] ? ((~sample) + SAMPLE_BITS'(1)) : sample;
        bsum = (64'(bprod3_reg) + 64'd32768) >> 16;
        side4_next.neg  = neg3_reg;
        side4_next.pow  = pow3_reg;
        side4_next.bmag = clamp33(bsum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smag_reg   <= smag_next;
            neg1_reg   <= sample[SAMPLE_BITS-1];
            xmag2_reg  <= XW'(smag_reg) * XW'(pre_gain);
            neg2_reg   <= neg1_reg;
            xmag3_reg  <= xmag2_reg;
            neg3_reg   <= neg2_reg;
            pow3_reg   <= 48'(xmag2_reg) > 48'(threshold);
            bprod3_reg <= BPW'(xmag2_reg) * BPW'(post_gain);
            xmag4_reg  <= xmag3_reg;
            side4_reg  <= side4_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign xmag      = xmag4_reg;
    assign side      = side4_reg;

endmodule

// ===== design/tplc_log2.sv =====
// Logarithm unit: leading-one search, normalization and one squaring
// stage per fraction bit, giving log2(x/256) with 28 fraction bits.
// Depends on tplc_pkg.
module tplc_log2 #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [SAMPLE_BITS+15:0]        xmag,
    input  tplc_pkg::side_t                side,
    output logic                           out_valid,
    output logic signed [tplc_pkg::LG_W-1:0] lg,
    output tplc_pkg::side_t                side_out
);
    import tplc_pkg::*;

    localparam int XW = SAMPLE_BITS + 16;
    localparam int MW = $clog2(XW);
    localparam int NS = LOG_FRAC;

    logic             vld_a_reg;
    logic [MW-1:0]    msb_a_reg, msb_next;
    logic [XW-1:0]    xmag_a_reg;
    side_t            side_a_reg;
    logic [XW+30:0]   wide;

    logic             vld_reg  [0:NS];
    logic [31:0]      z_reg    [0:NS];
    logic [NS-1:0]    frac_reg [0:NS];
    logic [MW-1:0]    msb_reg  [0:NS];
    side_t            side_reg [0:NS];

    logic                    vld_out_reg;
    logic signed [LG_W-1:0]  lg_reg, lg_next;
    side_t                   side_out_reg;

    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (xmag[i])
            begin
                msb_next = MW'(i);
            end
        end
        wide    = {xmag_a_reg, 31'b0} >> msb_a_reg;
        lg_next = LG_W'({msb_reg[NS], frac_reg[NS]}) - LG_W'(64'd8 << LOG_FRAC);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg   <= 1'b0;
            vld_reg[0]  <= 1'b0;
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg   <= in_valid;
            vld_reg[0]  <= vld_a_reg;
            vld_out_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            msb_a_reg    <= msb_next;
            xmag_a_reg   <= xmag;
            side_a_reg   <= side;
            z_reg[0]     <= wide[31:0];
            frac_reg[0]  <= '0;
            msb_reg[0]   <= msb_a_reg;
            side_reg[0]  <= side_a_reg;
            lg_reg       <= lg_next;
            side_out_reg <= side_reg[NS];
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_sq
        logic [63:0] sq;
        logic [32:0] y;
        logic [31:0] z_next;

        always_comb
        begin
            sq     = 64'(z_reg[g]) * 64'(z_reg[g]);
            y      = sq[63:31];
            z_next = y[32] ? y[32:1] : y[31:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g+1] <= vld_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                z_reg[g+1]    <= z_next;
                frac_reg[g+1] <= {frac_reg[g][NS-2:0], y[32]};
                msb_reg[g+1]  <= msb_reg[g];
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign out_valid = vld_out_reg;
    assign lg        = lg_reg;
    assign side_out  = side_out_reg;

endmodule

// ===== design/tplc_exp2.sv =====
// Power unit: scales the logarithm by the exponent and evaluates 2^frac
// as a truncated series, three stages per term. Depends on tplc_pkg.
module tplc_exp2 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [tplc_pkg::LG_W-1:0]  lg,
    input  tplc_pkg::side_t                   side,
    input  logic [15:0]                       exponent,
    output logic                              out_valid,
    output logic [31:0]                       fm,
    output logic signed [tplc_pkg::IP_W-1:0]  ip,
    output tplc_pkg::side_t                   side_out
);
    import tplc_pkg::*;

    logic                   vld_p_reg;
    logic signed [P_W-1:0]  p_reg, p_next;
    side_t                  side_p_reg;
    logic [59:0]            tprod;

    logic                   vld_reg  [0:TERMS];
    logic [30:0]            term_reg [0:TERMS];
    logic [31:0]            sum_reg  [0:TERMS];
    logic [29:0]            t_reg    [0:TERMS];
    logic signed [IP_W-1:0] ip_reg   [0:TERMS];
    side_t                  side_reg [0:TERMS];

    always_comb
    begin
        p_next = P_W'(lg) * P_W'($signed({1'b0, exponent}));
        tprod  = 60'(p_reg[41:12]) * 60'(LN2_Q30);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_p_reg  <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_p_reg  <= in_valid;
            vld_reg[0] <= vld_p_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg       <= p_next;
            side_p_reg  <= side;
            term_reg[0] <= 31'h4000_0000;
            sum_reg[0]  <= 32'h4000_0000;
            t_reg[0]    <= tprod[59:30];
            ip_reg[0]   <= p_reg[P_W-1:42];
            side_reg[0] <= side_p_reg;
        end
    end

    for (genvar g = 1; g <= TERMS; g++)
    begin : g_term
        localparam int K = g;
        localparam logic [36:0] RK = recip(K);

        logic                   va_reg, vb_reg;
        logic [30:0]            ma_reg, mb_reg, qb_reg;
        logic [31:0]            suma_reg, sumb_reg;
        logic [29:0]            ta_reg, tb_reg;
        logic signed [IP_W-1:0] ipa_reg, ipb_reg;
        side_t                  sidea_reg, sideb_reg;
        logic [60:0]            mprod;
        logic [67:0]            qprod;
        logic [34:0]            qk, rem;
        logic [30:0]            term_next;

        always_comb
        begin
            mprod     = 61'(term_reg[g-1]) * 61'(t_reg[g-1]);
            qprod     = 68'(ma_reg) * 68'(RK);
            qk        = 35'(qb_reg) * 35'(K);
            rem       = 35'(mb_reg) - qk;
            term_next = qb_reg + 31'(rem >= 35'(K));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg     <= 1'b0;
                vb_reg     <= 1'b0;
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                va_reg     <= vld_reg[g-1];
                vb_reg     <= va_reg;
                vld_reg[g] <= vb_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ma_reg      <= mprod[60:30];
                suma_reg    <= sum_reg[g-1];
                ta_reg      <= t_reg[g-1];
                ipa_reg     <= ip_reg[g-1];
                sidea_reg   <= side_reg[g-1];
                mb_reg      <= ma_reg;
                qb_reg      <= qprod[66:36];
                sumb_reg    <= suma_reg;
                tb_reg      <= ta_reg;
                ipb_reg     <= ipa_reg;
                sideb_reg   <= sidea_reg;
                term_reg[g] <= term_next;
                sum_reg[g]  <= sumb_reg + 32'(term_next);
                t_reg[g]    <= tb_reg;
                ip_reg[g]   <= ipb_reg;
                side_reg[g] <= sideb_reg;
            end
        end
    end

    assign out_valid = vld_reg[TERMS];
    assign fm        = sum_reg[TERMS];
    assign ip        = ip_reg[TERMS];
    assign side_out  = side_reg[TERMS];

endmodule

// ===== design/tplc_scale.sv =====
// Output stage: post-gain product, shift with rounding, saturation and
// sign restore into the output register. Depends on tplc_pkg.
module tplc_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [31:0]                       fm,
    input  logic signed [tplc_pkg::IP_W-1:0]  ip,
    input  tplc_pkg::side_t                   side,
    input  logic [15:0]                       post_gain,
    output logic                              out_valid,
    output logic [31:0]                       result,
    output logic                              saturated
);
    import tplc_pkg::*;

    logic               v1_reg, v2_reg, v3_reg;
    logic [47:0]        prod_reg;
    logic signed [11:0] sh_reg, nsh;
    logic               pgz_reg;
    side_t              side1_reg;
    logic [32:0]        mag_reg, mag_next;
    logic               neg2_reg;
    logic [63:0]        sv, rv;
    logic [5:0]         s;
    logic [32:0]        lim, mlim;
    logic               sat_next;
    logic [31:0]        result_reg, result_next;
    logic               sat_reg;

    always_comb
    begin
        nsh = -sh_reg;
        s   = nsh[5:0];
        sv  = 64'(prod_reg) << sh_reg[4:0];
        rv  = (64'(prod_reg) + (64'd1 << (s - 6'd1))) >> s;
        if (!side1_reg.pow)
        begin
            mag_next = side1_reg.bmag;
        end
        else if (pgz_reg)
        begin
            mag_next = '0;
        end
        else if (sh_reg > 12'sd16)
        begin
            mag_next = MAG_BIG;
        end
        else if (sh_reg >= 12'sd0)
        begin
            mag_next = clamp33(sv);
        end
        else if (sh_reg < -12'sd48)
        begin
            mag_next = '0;
        end
        else
        begin
            mag_next = clamp33(rv);
        end

        lim         = neg2_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        sat_next    = mag_reg > lim;
        mlim        = sat_next ? lim : mag_reg;
        result_next = neg2_reg ? (32'd0 - mlim[31:0]) : mlim[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= 48'(fm) * 48'(post_gain);
            sh_reg     <= 12'(ip) - 12'sd38;
            pgz_reg    <= (post_gain == 16'd0);
            side1_reg  <= side;
            mag_reg    <= mag_next;
            neg2_reg   <= side1_reg.neg;
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid = v3_reg;
    assign result    = result_reg;
    assign saturated = sat_reg;

endmodule

// ===== design/threshold_power_law_compander_core.sv =====
// Threshold power-law compander, top level.
// Depends on tplc_pkg, tplc_front, tplc_log2, tplc_exp2 and tplc_scale.
//
// Samples enter on the s_ stream and results leave on the m_ stream, one
// result for every request. Each result is the sample scaled by pre_gain,
// passed through sign*|x|^exponent when |x| is above threshold, scaled by
// post_gain, rounded and clipped to 32 bits; m_tuser flags a clip.
// The pipeline takes one request per cycle unless the output stalls. It has
// 4 front stages, 31 for the logarithm (one squaring multiplier per fraction
// bit), 38 for the exponent product and the twelve-term series (three
// stages per term) and 3 output stages. When the receiver holds m_tready
// low with a result waiting, the whole pipeline holds and s_tready falls
// in the same cycle; nothing is dropped. Reset clears all valid bits and
// loads the registers with pre_gain 1.0, threshold 0, exponent 5407 and
// post_gain 1.0. The user must write registers through cfg_we, cfg_addr and
// cfg_wdata only while no request is in flight, not enforced by the block.
module threshold_power_law_compander_core #(
    parameter int SAMPLE_BITS = 16,
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // result
    output logic                  m_tuser,   // saturated
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [30:0]           cfg_wdata
);
    import tplc_pkg::*;

    localparam int XW = SAMPLE_BITS + 16;

    logic        en;
    logic [15:0] pre_gain_reg, exponent_reg, post_gain_reg;
    logic [30:0] threshold_reg;

    logic                    fr_valid, lg_valid, ex_valid;
    logic [XW-1:0]           fr_xmag;
    side_t                   fr_side, lg_side, ex_side;
    logic signed [LG_W-1:0]  lg_val;
    logic [31:0]             ex_fm;
    logic signed [IP_W-1:0]  ex_ip;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_gain_reg  <= 16'd256;
            threshold_reg <= 31'd0;
            exponent_reg  <= 16'd5407;
            post_gain_reg <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_PRE_GAIN:  pre_gain_reg  <= cfg_wdata[15:0];
                CFG_THRESHOLD: threshold_reg <= cfg_wdata;
                CFG_EXPONENT:  exponent_reg  <= cfg_wdata[15:0];
                CFG_POST_GAIN: post_gain_reg <= cfg_wdata[15:0];
                default:       ;
            endcase
        end
    end

    tplc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .sample    (s_tdata[SAMPLE_BITS-1:0]),
        .pre_gain  (pre_gain_reg),
        .threshold (threshold_reg),
        .post_gain (post_gain_reg),
        .out_valid (fr_valid),
        .xmag      (fr_xmag),
        .side      (fr_side)
    );

    tplc_log2 #(.SAMPLE_BITS(SAMPLE_BITS)) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .xmag      (fr_xmag),
        .side      (fr_side),
        .out_valid (lg_valid),
        .lg        (lg_val),
        .side_out  (lg_side)
    );

    tplc_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lg_valid),
        .lg        (lg_val),
        .side      (lg_side),
        .exponent  (exponent_reg),
        .out_valid (ex_valid),
        .fm        (ex_fm),
        .ip        (ex_ip),
        .side_out  (ex_side)
    );

    tplc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ex_valid),
        .fm        (ex_fm),
        .ip        (ex_ip),
        .side      (ex_side),
        .post_gain (post_gain_reg),
        .out_valid (m_tvalid),
        .result    (m_tdata),
        .saturated (m_tuser)
    );

endmodule

// ===== design/tplc_checker.sv =====
// Port-level checks for the compander top level, attached by bind.
// Depends only on the top level's ports.
module tplc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not track the output stall");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
        else $error("saturation flag on a value that is not a limit");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind threshold_power_law_compander_core tplc_checker u_tplc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
